// File: hdl/multiboot_word_encryptor_defines.svh
// ----------------------------------------------------------------------------
// multiboot_word_encryptor_defines
// Assertion macros shared by the encryptor RTL.
// ----------------------------------------------------------------------------
`ifndef MULTIBOOT_WORD_ENCRYPTOR_DEFINES_SVH
`define MULTIBOOT_WORD_ENCRYPTOR_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define MWE_ASSERT_IMPL(name, clk_sig, rst_sig, ante, cons) \
  name: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

`define MWE_ASSERT_NEXT(name, clk_sig, rst_sig, ante, cons) \
  name: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`else

`define MWE_ASSERT_IMPL(name, clk_sig, rst_sig, ante, cons)

`define MWE_ASSERT_NEXT(name, clk_sig, rst_sig, ante, cons)

`endif

`endif

// File: hdl/mwe_pkg.sv
// ----------------------------------------------------------------------------
// mwe_pkg
// Types, constants and helper functions of the boot link word encryptor.
// ----------------------------------------------------------------------------
package mwe_pkg;

  localparam int unsigned WORD_W    = 32;
  localparam int unsigned SIZE_W    = 19;
  localparam int unsigned CRC_W     = 16;
  localparam int unsigned REQ_W     = 2;
  localparam int unsigned KIND_W    = 3;

  localparam int unsigned MAX_IMAGE_BYTES_DEF = 262144;
  localparam int unsigned QUEUE_DEPTH_DEF     = 2;

  localparam logic [SIZE_W-1:0] UPLOAD_SIZE_RESET = SIZE_W'(512);
  localparam logic [SIZE_W-1:0] HS_SIZE_BASE      = SIZE_W'(12'h200);
  localparam logic [SIZE_W-1:0] HEADER_END        = SIZE_W'(8'hC0);
  localparam logic [SIZE_W-1:0] OFFSET_STEP       = SIZE_W'(4);

  localparam logic [CRC_W-1:0]  CRC_POLY = 16'hA1C1;
  localparam logic [CRC_W-1:0]  CRC_INIT = 16'h15A0;

  localparam logic [WORD_W-1:0] KEY_MULT   = 32'h6177_614B;
  localparam logic [WORD_W-1:0] XOR_TAIL   = 32'h2079_6220;
  localparam logic [WORD_W-1:0] RAW_XOR    = 32'h7365_646F;
  localparam logic [WORD_W-1:0] POS_BIAS   = 32'h0200_0000;
  localparam logic [WORD_W-1:0] HS_A_BASE  = 32'h0038_0000;
  localparam logic [WORD_W-1:0] HS_MARK    = 32'h8080_8080;
  localparam logic [WORD_W-1:0] HS_KEY_A   = 32'h4B61_7761;
  localparam logic [WORD_W-1:0] HS_KEY_B   = 32'h7365_646F;

  // request type codes on the input channel
  localparam logic [REQ_W-1:0] REQ_START    = 2'd0;
  localparam logic [REQ_W-1:0] REQ_DATA     = 2'd1;
  localparam logic [REQ_W-1:0] REQ_FINISH   = 2'd2;
  localparam logic [REQ_W-1:0] REQ_RESERVED = 2'd3;

  // result kind codes
  localparam logic [KIND_W-1:0] KIND_HANDSHAKE = 3'd0;
  localparam logic [KIND_W-1:0] KIND_PLAIN     = 3'd1;
  localparam logic [KIND_W-1:0] KIND_ENCRYPTED = 3'd2;
  localparam logic [KIND_W-1:0] KIND_CHECKSUM  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_OVERRUN   = 3'd4;

  typedef enum logic [1:0] {
    OP_START,
    OP_DATA,
    OP_FINISH
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [WORD_W-1:0] word;
  } q_entry_t;

  function automatic logic [WORD_W-1:0] swap32(input logic [WORD_W-1:0] v);
    return {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

  // 16 steps of the reflected checksum, data consumed LSB first
  function automatic logic [CRC_W-1:0] crc_half(input logic [CRC_W-1:0] crc_in,
                                                input logic [15:0] val);
    logic [CRC_W-1:0] c;
    logic             fb;
    c = crc_in;
    for (int k = 0; k < 16; k++) begin
      fb = c[0] ^ val[k];
      c  = c >> 1;
      if (fb) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

  function automatic logic [WORD_W-1:0] handshake_key(input logic [SIZE_W-1:0] size);
    logic [SIZE_W-1:0] d;
    logic [14:0]       s;
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] sum;
    logic [WORD_W-1:0] m;
    d   = size - HS_SIZE_BASE;
    s   = d[17:3];
    a   = HS_A_BASE | {15'b0, s[14], 1'b0, s[13:7], 1'b0, s[6:0]};
    sum = (a >> 8) + (a >> 16) + a;
    m   = {sum[7:0], 24'b0} | a | HS_MARK;
    if (!m[9]) begin
      return swap32(m) ^ HS_KEY_A;
    end
    return swap32(m) ^ HS_KEY_B;
  endfunction

endpackage

// File: hdl/mwe_ifs.sv
// ----------------------------------------------------------------------------
// mwe_ifs
// Channel interfaces: request, result and configuration write.
// ----------------------------------------------------------------------------
interface mwe_req_if import mwe_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic [WORD_W-1:0] data_word;

  modport source (output valid, output req_type, output data_word, input ready);
  modport sink   (input valid, input req_type, input data_word, output ready);
endinterface

interface mwe_res_if import mwe_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] out_word;
  logic [KIND_W-1:0] word_kind;

  modport source (output valid, output out_word, output word_kind, input ready);
  modport sink   (input valid, input out_word, input word_kind, output ready);
endinterface

interface mwe_cfg_if import mwe_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [SIZE_W-1:0] upload_size;

  modport source (output valid, output upload_size, input ready);
  modport sink   (input valid, input upload_size, output ready);
endinterface

// File: hdl/multiboot_word_encryptor.sv
// ----------------------------------------------------------------------------
// multiboot_word_encryptor
// Upload word encryptor with running checksum for a serial boot link.
// ----------------------------------------------------------------------------
// Channels: req carries req_type and data_word (start with raw session key,
// data word, finish); res returns out_word and word_kind, one result per
// start, data or finish request; cfg writes upload_size and is always ready.
// A request is taken into a two-entry queue; the back end pops it, registers
// the key multiply and low checksum half at the pop, then computes the high
// half and the XOR mask and registers them with the result.
// The back end pops no new request until the last one has committed, as the
// key recurrence needs the updated key; short bursts are absorbed by the queue.
// Reserved request type 3 is accepted and dropped without a result.
// Reset: upload_size 512, session key 0, checksum 0x15a0, offset 0, queue
// empty, no result pending.
// When res stalls, the result register holds, the back end stops and the
// queue fills; req.ready falls once the queue is full.
// ----------------------------------------------------------------------------
module multiboot_word_encryptor import mwe_pkg::*; #(
  parameter int unsigned MAX_IMAGE_BYTES = MAX_IMAGE_BYTES_DEF,
  parameter int unsigned QUEUE_DEPTH     = QUEUE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  mwe_req_if.sink   req,
  mwe_res_if.source res,
  mwe_cfg_if.sink   cfg
);

  q_entry_t          push_entry;
  q_entry_t          head;
  logic              push;
  logic              full;
  logic              pop;
  logic              empty;
  logic [SIZE_W-1:0] eff_size;

  mwe_front #(
    .MAX_IMAGE_BYTES (MAX_IMAGE_BYTES)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .cfg        (cfg),
    .push_entry (push_entry),
    .push       (push),
    .full       (full),
    .eff_size   (eff_size)
  );

  mwe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (full),
    .pop        (pop),
    .head       (head),
    .empty      (empty)
  );

  mwe_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .empty    (empty),
    .pop      (pop),
    .eff_size (eff_size),
    .res      (res)
  );

endmodule

// File: hdl/mwe_front.sv
// ----------------------------------------------------------------------------
// mwe_front
// Accepts requests, classifies them and holds the upload size register.
// ----------------------------------------------------------------------------
module mwe_front import mwe_pkg::*; #(
  parameter int unsigned MAX_IMAGE_BYTES = MAX_IMAGE_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  mwe_req_if.sink           req,
  mwe_cfg_if.sink           cfg,
  output q_entry_t          push_entry,
  output logic              push,
  input  logic              full,
  output logic [SIZE_W-1:0] eff_size
);

  localparam logic [SIZE_W-1:0] SIZE_LIMIT = SIZE_W'(MAX_IMAGE_BYTES);

  logic [SIZE_W-1:0] upload_size;
  logic              known;
  op_t               op;

  assign cfg.ready = 1'b1;
  assign req.ready = !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      upload_size <= UPLOAD_SIZE_RESET;
    end else if (cfg.valid) begin
      upload_size <= cfg.upload_size;
    end
  end

  assign eff_size = (upload_size > SIZE_LIMIT) ? SIZE_LIMIT : upload_size;

  // reserved request type is taken and dropped
  always_comb begin
    known = 1'b1;
    op    = OP_DATA;
    case (req.req_type)
      REQ_START:  op = OP_START;
      REQ_DATA:   op = OP_DATA;
      REQ_FINISH: op = OP_FINISH;
      default:    known = 1'b0;
    endcase
  end

  assign push            = req.valid && !full && known;
  assign push_entry.op   = op;
  assign push_entry.word = req.data_word;

endmodule

// File: hdl/mwe_queue.sv
// ----------------------------------------------------------------------------
// mwe_queue
// Short request queue between the front and the back.
// ----------------------------------------------------------------------------
`include "multiboot_word_encryptor_defines.svh"

module mwe_queue import mwe_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  q_entry_t push_entry,
  output logic     full,
  input  logic     pop,
  output q_entry_t head,
  output logic     empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  q_entry_t          entries [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              do_push;
  logic              do_pop;

  assign full    = (count == FULL_CNT);
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  `MWE_ASSERT_IMPL(a_count_bound, clk, rst, 1'b1, count <= FULL_CNT)
  `MWE_ASSERT_NEXT(a_push_lands, clk, rst, do_push && !do_pop, !empty)

endmodule

// File: hdl/mwe_back.sv
// ----------------------------------------------------------------------------
// mwe_back
// Executes queued requests: checksum, key recurrence and word encryption.
// ----------------------------------------------------------------------------
`include "multiboot_word_encryptor_defines.svh"

module mwe_back import mwe_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  q_entry_t          head,
  input  logic              empty,
  output logic              pop,
  input  logic [SIZE_W-1:0] eff_size,
  mwe_res_if.source         res
);

  typedef enum logic {
    ST_IDLE,
    ST_WORK
  } state_t;

  state_t            state;
  op_t               op_q;
  logic [WORD_W-1:0] word_q;
  logic [WORD_W-1:0] prod_q;
  logic [CRC_W-1:0]  crc_mid_q;

  logic [WORD_W-1:0] session_key;
  logic [CRC_W-1:0]  running_checksum;
  logic [SIZE_W-1:0] byte_offset;

  logic              out_valid;
  logic [WORD_W-1:0] out_word;
  logic [KIND_W-1:0] out_kind;

  logic              commit;
  logic [WORD_W-1:0] key_adv;
  logic [WORD_W-1:0] enc_mask;
  logic [WORD_W-1:0] session_key_next;
  logic [CRC_W-1:0]  running_checksum_next;
  logic [SIZE_W-1:0] byte_offset_next;
  logic [WORD_W-1:0] out_word_next;
  logic [KIND_W-1:0] out_kind_next;

  assign pop    = (state == ST_IDLE) && !empty;
  assign commit = (state == ST_WORK) && (!out_valid || res.ready);

  assign res.valid     = out_valid;
  assign res.out_word  = out_word;
  assign res.word_kind = out_kind;

  assign key_adv  = prod_q + WORD_W'(1);
  assign enc_mask = key_adv ^ (WORD_W'(0) - (WORD_W'(byte_offset) + POS_BIAS)) ^ XOR_TAIL;

  always_comb begin
    session_key_next      = session_key;
    running_checksum_next = running_checksum;
    byte_offset_next      = byte_offset;
    out_word_next         = '0;
    out_kind_next         = KIND_OVERRUN;
    case (op_q)
      OP_START: begin
        session_key_next      = swap32(word_q ^ RAW_XOR);
        running_checksum_next = CRC_INIT;
        byte_offset_next      = '0;
        out_word_next         = swap32(handshake_key(eff_size));
        out_kind_next         = KIND_HANDSHAKE;
      end
      OP_DATA: begin
        if (byte_offset >= eff_size) begin
          out_word_next = '0;
          out_kind_next = KIND_OVERRUN;
        end else if (byte_offset < HEADER_END) begin
          out_word_next    = word_q;
          out_kind_next    = KIND_PLAIN;
          byte_offset_next = byte_offset + OFFSET_STEP;
        end else begin
          running_checksum_next = crc_half(crc_mid_q, word_q[31:16]);
          session_key_next      = key_adv;
          out_word_next         = word_q ^ enc_mask;
          out_kind_next         = KIND_ENCRYPTED;
          byte_offset_next      = byte_offset + OFFSET_STEP;
        end
      end
      OP_FINISH: begin
        session_key_next = key_adv;
        out_word_next    = {eff_size[15:0], running_checksum} ^ enc_mask;
        out_kind_next    = KIND_CHECKSUM;
      end
      default: begin
        out_word_next = '0;
        out_kind_next = KIND_OVERRUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      session_key      <= '0;
      running_checksum <= CRC_INIT;
      byte_offset      <= '0;
      out_valid        <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (pop) begin
            state <= ST_WORK;
          end
        end
        ST_WORK: begin
          if (commit) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
      if (commit) begin
        session_key      <= session_key_next;
        running_checksum <= running_checksum_next;
        byte_offset      <= byte_offset_next;
        out_valid        <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // at pop: product and low half of the checksum; at commit: result word and kind
  always_ff @(posedge clk) begin
    if (pop) begin
      op_q      <= head.op;
      word_q    <= head.word;
      prod_q    <= session_key * KEY_MULT;
      crc_mid_q <= crc_half(running_checksum, head.word[15:0]);
    end
    if (commit) begin
      out_word <= out_word_next;
      out_kind <= out_kind_next;
    end
  end

  `MWE_ASSERT_NEXT(a_pop_starts_work, clk, rst, pop, state == ST_WORK)
  `MWE_ASSERT_IMPL(a_overrun_zero, clk, rst, out_valid && out_kind == KIND_OVERRUN, out_word == '0)
  `MWE_ASSERT_NEXT(a_start_clears, clk, rst, commit && op_q == OP_START, byte_offset == '0 && running_checksum == CRC_INIT)

endmodule
